// ===== rtl/core/lps_pkg.sv =====
// lps_pkg: shared types, constants and mask helpers of the led pattern sequencer
// no dependencies; compiled first

package lps_pkg;

  localparam int LED_COUNT     = 9;
  localparam int SPARKLE_STEPS = 20;

  localparam int KIND_W  = 1;
  localparam int SPARK_W = 4;
  localparam int MASK_W  = 9;
  localparam int IDX_W   = 5;
  localparam int PHASE_W = 3;
  localparam int STEP_W  = 16;
  localparam int RUN_W   = 24;
  localparam int TAIL_W  = 4;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [STEP_W-1:0] STEP_TICKS_RST  = 16'd74;
  localparam logic [RUN_W-1:0]  RUN_TICKS_RST   = 24'd300000;
  localparam logic [TAIL_W-1:0] TAIL_LENGTH_RST = 4'd3;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_STEP_TICKS  = 2'd0;
  localparam logic [1:0] REG_RUN_TICKS   = 2'd1;
  localparam logic [1:0] REG_TAIL_LENGTH = 2'd2;

  localparam logic [KIND_W-1:0] KIND_TICK  = 1'b0;
  localparam logic [KIND_W-1:0] KIND_PRESS = 1'b1;

  localparam logic [PHASE_W-1:0] PH_SNAKE_FWD = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SNAKE_BWD = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SWEEP_FWD = 3'd2;
  localparam logic [PHASE_W-1:0] PH_SWEEP_REV = 3'd3;
  localparam logic [PHASE_W-1:0] PH_SPARKLE   = 3'd4;

  localparam logic [3:0] SWEEP_PIN [LED_COUNT] = '{4'd8, 4'd0, 4'd1, 4'd7, 4'd6,
                                                   4'd2, 4'd3, 4'd5, 4'd4};
  localparam logic [3:0] SNAKE_PIN [LED_COUNT] = '{4'd2, 4'd6, 4'd0, 4'd4, 4'd8,
                                                   4'd5, 4'd1, 4'd7, 4'd3};

  typedef struct packed {
    logic [STEP_W-1:0] step_ticks;
    logic [RUN_W-1:0]  run_ticks;
    logic [TAIL_W-1:0] tail_length;
  } lps_cfg_t;

  typedef struct packed {
    logic [MASK_W-1:0] led_mask;
    logic              running;
  } lps_result_t;

  function automatic logic [MASK_W-1:0] sweep_mask(input logic [3:0] idx);
    logic [MASK_W-1:0] m;
    m = '0;
    if (idx < 4'(LED_COUNT)) m = MASK_W'(1) << SWEEP_PIN[idx];
    return m;
  endfunction

  function automatic logic [MASK_W-1:0] snake_mask(input logic [3:0] idx);
    logic [MASK_W-1:0] m;
    m = '0;
    if (idx < 4'(LED_COUNT)) m = MASK_W'(1) << SNAKE_PIN[idx];
    return m;
  endfunction

  // lights the led(s) of a step that is beginning; in a snake phase also darkens the tail end
  function automatic logic [MASK_W-1:0] begin_lit(input logic [MASK_W-1:0]  lit,
                                                  input logic [PHASE_W-1:0] ph,
                                                  input logic [IDX_W-1:0]   idx,
                                                  input logic [TAIL_W-1:0]  tail,
                                                  input logic [SPARK_W-1:0] sled);
    logic [MASK_W-1:0] m;
    logic [IDX_W-1:0]  back;
    m    = lit;
    back = idx - {1'b0, tail};
    case (ph)
      PH_SNAKE_FWD, PH_SNAKE_BWD: begin
        if (idx < IDX_W'(LED_COUNT)) m = m | snake_mask(idx[3:0]);
        // tail end goes dark
        if (idx >= {1'b0, tail} && back < IDX_W'(LED_COUNT)) m = m & ~snake_mask(back[3:0]);
      end
      PH_SWEEP_FWD, PH_SWEEP_REV: begin
        if (idx < IDX_W'(LED_COUNT)) m = m | sweep_mask(idx[3:0]);
      end
      PH_SPARKLE: begin
        m = m | sweep_mask(sled);
      end
      default: begin
      end
    endcase
    return m;
  endfunction

  // clears the led lit by a sweep or sparkle step that is ending
  function automatic logic [MASK_W-1:0] end_lit(input logic [MASK_W-1:0]  lit,
                                                input logic [PHASE_W-1:0] ph,
                                                input logic [IDX_W-1:0]   idx,
                                                input logic [SPARK_W-1:0] sled);
    logic [MASK_W-1:0] m;
    m = lit;
    case (ph)
      PH_SWEEP_FWD, PH_SWEEP_REV: begin
        if (idx < IDX_W'(LED_COUNT)) m = m & ~sweep_mask(idx[3:0]);
      end
      PH_SPARKLE: begin
        m = m & ~sweep_mask(sled);
      end
      default: begin
      end
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/core/lps_in_if.sv =====
// lps_in_if: input channel of the led pattern sequencer (valid/ready plus word)
// depends on lps_pkg

interface lps_in_if;
  logic                        valid;
  logic                        ready;
  logic [lps_pkg::KIND_W-1:0]  kind;
  logic [lps_pkg::SPARK_W-1:0] sparkle_index;

  modport source (output valid, output kind, output sparkle_index, input ready);
  modport sink   (input valid, input kind, input sparkle_index, output ready);
endinterface

// ===== rtl/core/lps_out_if.sv =====
// lps_out_if: result channel of the led pattern sequencer (valid/ready plus word)
// depends on lps_pkg

interface lps_out_if;
  logic                       valid;
  logic                       ready;
  logic [lps_pkg::MASK_W-1:0] led_mask;
  logic                       running;

  modport source (output valid, output led_mask, output running, input ready);
  modport sink   (input valid, input led_mask, input running, output ready);
endinterface

// ===== rtl/core/lps_cfg_regs.sv =====
// lps_cfg_regs: apb-style register file for step_ticks, run_ticks, tail_length
// depends on lps_pkg

module lps_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lps_pkg::ADDR_W-1:0]  paddr,
  input  logic [lps_pkg::DATA_W-1:0]  pwdata,
  output logic [lps_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output lps_pkg::lps_cfg_t           cfg
);
  import lps_pkg::*;

  logic [STEP_W-1:0] step_ticks_r;
  logic [RUN_W-1:0]  run_ticks_r;
  logic [TAIL_W-1:0] tail_length_r;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_ticks_r  <= STEP_TICKS_RST;
      run_ticks_r   <= RUN_TICKS_RST;
      tail_length_r <= TAIL_LENGTH_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_STEP_TICKS:  step_ticks_r  <= pwdata[STEP_W-1:0];
        REG_RUN_TICKS:   run_ticks_r   <= pwdata[RUN_W-1:0];
        REG_TAIL_LENGTH: tail_length_r <= pwdata[TAIL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_STEP_TICKS:  prdata = DATA_W'(step_ticks_r);
      REG_RUN_TICKS:   prdata = DATA_W'(run_ticks_r);
      REG_TAIL_LENGTH: prdata = DATA_W'(tail_length_r);
      default:         prdata = '0;
    endcase
  end

  assign cfg.step_ticks  = step_ticks_r;
  assign cfg.run_ticks   = run_ticks_r;
  assign cfg.tail_length = tail_length_r;

endmodule

// ===== rtl/core/lps_seq_core.sv =====
// lps_seq_core: sequencer state and the combinational next-state logic per word
// depends on lps_pkg

module lps_seq_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        item_valid,
  input  logic [lps_pkg::KIND_W-1:0]  item_kind,
  input  logic [lps_pkg::SPARK_W-1:0] item_spark,
  input  lps_pkg::lps_cfg_t           cfg,
  output lps_pkg::lps_result_t        res_nxt
);
  import lps_pkg::*;

  logic               active_r,   active_nxt;
  logic [RUN_W-1:0]   elapsed_r,  elapsed_nxt;
  logic [STEP_W-1:0]  timer_r,    timer_nxt;
  logic [PHASE_W-1:0] phase_r,    phase_nxt;
  logic [IDX_W-1:0]   idx_r,      idx_nxt;
  logic [MASK_W-1:0]  lit_r,      lit_nxt;
  logic               pending_r,  pending_nxt;
  logic [SPARK_W-1:0] sled_r,     sled_nxt;

  logic [STEP_W-1:0]  limit;
  logic [RUN_W-1:0]   elapsed_inc;
  logic [STEP_W-1:0]  timer_inc;
  logic [SPARK_W-1:0] spark_sat;
  logic [PHASE_W-1:0] adv_phase;
  logic [IDX_W-1:0]   adv_idx;
  logic [MASK_W-1:0]  ended_lit;

  assign limit       = (cfg.step_ticks == '0) ? STEP_W'(1) : cfg.step_ticks;
  assign elapsed_inc = (elapsed_r != '1) ? elapsed_r + RUN_W'(1) : elapsed_r;
  assign timer_inc   = (timer_r != '1) ? timer_r + STEP_W'(1) : timer_r;
  assign spark_sat   = (item_spark > SPARK_W'(LED_COUNT - 1)) ? SPARK_W'(LED_COUNT - 1)
                                                              : item_spark;
  assign ended_lit   = end_lit(lit_r, phase_r, idx_r, sled_r);

  // where the next step of the cycle lies
  always_comb begin
    adv_phase = phase_r;
    adv_idx   = idx_r;
    case (phase_r)
      PH_SNAKE_FWD: begin
        if ({1'b0, idx_r} + 6'd1 < 6'(LED_COUNT) + {2'b0, cfg.tail_length}) begin
          adv_idx = idx_r + IDX_W'(1);
        end else begin
          adv_phase = PH_SNAKE_BWD;
          adv_idx   = IDX_W'(LED_COUNT - 1) + {1'b0, cfg.tail_length};
        end
      end
      PH_SNAKE_BWD: begin
        if (idx_r != '0) begin
          adv_idx = idx_r - IDX_W'(1);
        end else begin
          adv_phase = PH_SWEEP_FWD;
          adv_idx   = '0;
        end
      end
      PH_SWEEP_FWD: begin
        if (idx_r < IDX_W'(LED_COUNT - 1)) begin
          adv_idx = idx_r + IDX_W'(1);
        end else begin
          adv_phase = PH_SWEEP_REV;
          adv_idx   = IDX_W'(LED_COUNT - 1);
        end
      end
      PH_SWEEP_REV: begin
        if (idx_r != '0) begin
          adv_idx = idx_r - IDX_W'(1);
        end else begin
          adv_phase = PH_SPARKLE;
          adv_idx   = '0;
        end
      end
      PH_SPARKLE: begin
        if (idx_r < IDX_W'(SPARKLE_STEPS - 1)) begin
          adv_idx = idx_r + IDX_W'(1);
        end else begin
          adv_phase = PH_SNAKE_FWD;
          adv_idx   = '0;
        end
      end
      default: begin
        adv_phase = PH_SNAKE_FWD;
        adv_idx   = '0;
      end
    endcase
  end

  always_comb begin
    active_nxt  = active_r;
    elapsed_nxt = elapsed_r;
    timer_nxt   = timer_r;
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    lit_nxt     = lit_r;
    pending_nxt = pending_r;
    sled_nxt    = sled_r;
    if (item_valid) begin
      if (item_kind == KIND_PRESS) begin
        if (active_r) begin
          pending_nxt = 1'b1;
        end else begin
          active_nxt  = 1'b1;
          pending_nxt = 1'b0;
          elapsed_nxt = '0;
          timer_nxt   = '0;
          phase_nxt   = PH_SNAKE_FWD;
          idx_nxt     = '0;
          lit_nxt     = begin_lit(lit_r, PH_SNAKE_FWD, '0, cfg.tail_length, spark_sat);
        end
      end else if (active_r) begin
        elapsed_nxt = elapsed_inc;
        timer_nxt   = timer_inc;
        if (timer_inc >= limit) begin
          if (pending_r || elapsed_inc >= cfg.run_ticks) begin
            active_nxt  = 1'b0;
            lit_nxt     = '0;
            pending_nxt = 1'b0;
          end else begin
            timer_nxt = '0;
            phase_nxt = adv_phase;
            idx_nxt   = adv_idx;
            lit_nxt   = begin_lit(ended_lit, adv_phase, adv_idx, cfg.tail_length, spark_sat);
            if (adv_phase == PH_SPARKLE) sled_nxt = spark_sat;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      elapsed_r <= '0;
      timer_r   <= '0;
      phase_r   <= PH_SNAKE_FWD;
      idx_r     <= '0;
      lit_r     <= '0;
      pending_r <= 1'b0;
      sled_r    <= '0;
    end else begin
      active_r  <= active_nxt;
      elapsed_r <= elapsed_nxt;
      timer_r   <= timer_nxt;
      phase_r   <= phase_nxt;
      idx_r     <= idx_nxt;
      lit_r     <= lit_nxt;
      pending_r <= pending_nxt;
      sled_r    <= sled_nxt;
    end
  end

  assign res_nxt.led_mask = lit_nxt;
  assign res_nxt.running  = active_nxt;

  // an idle sequencer keeps every led dark and no press latched
  a_idle_dark: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (lit_r == '0 && !pending_r))
    else $error("leds lit or press latched while idle");

  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_SPARKLE)
    else $error("phase left the cycle");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid && item_kind == KIND_PRESS && !active_r) |=>
      (active_r && phase_r == PH_SNAKE_FWD && idx_r == '0 && timer_r == '0))
    else $error("press while idle did not start a run");

  a_press_latched: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid && item_kind == KIND_PRESS && active_r) |=>
      (active_r && pending_r && $stable(lit_r)))
    else $error("press during a run not latched");

  a_sparkle_range: assert property (@(posedge clk) disable iff (!rst_n)
    sled_r < SPARK_W'(LED_COUNT))
    else $error("sparkle led out of range");

endmodule

// ===== rtl/core/led_pattern_sequencer.sv =====
// led_pattern_sequencer: top level with input register, result register and apb port
// depends on lps_pkg, lps_in_if, lps_out_if, lps_cfg_regs, lps_seq_core
//
// Each accepted word (a millisecond tick or a debounced button press) yields exactly one
// result word holding the led mask and the running flag after that word is applied. One
// word is accepted every clock unless the input stalls; the result goes through the input
// register and then through the next-state logic into the result register.
// The input register takes a new word while a result waits to be taken, so the input
// stalls only when both registers are full. Configuration is written through the apb
// port with no wait states and should change only while no word is in flight; a change
// made during a run takes effect on the next word.
// After reset the sequencer is idle with all leds off; there is no clearing pass.

module led_pattern_sequencer (
  input  logic                       clk,
  input  logic                       rst_n,
  lps_in_if.sink                     in_ch,
  lps_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lps_pkg::ADDR_W-1:0] paddr,
  input  logic [lps_pkg::DATA_W-1:0] pwdata,
  output logic [lps_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import lps_pkg::*;

  lps_cfg_t           cfg;
  lps_result_t        res_nxt;

  logic               in_valid_r;
  logic [KIND_W-1:0]  in_kind_r;
  logic [SPARK_W-1:0] in_spark_r;
  logic               out_valid_r;
  logic [MASK_W-1:0]  out_mask_r;
  logic               out_running_r;
  logic               step_en;

  // word in the input register moves on when the result register is free or being taken
  assign step_en     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || step_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_valid_r <= 1'b1;
    end else if (step_en) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_kind_r  <= in_ch.kind;
      in_spark_r <= in_ch.sparkle_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_mask_r    <= res_nxt.led_mask;
      out_running_r <= res_nxt.running;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.led_mask = out_mask_r;
  assign out_ch.running  = out_running_r;

  lps_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lps_seq_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (step_en),
    .item_kind  (in_kind_r),
    .item_spark (in_spark_r),
    .cfg        (cfg),
    .res_nxt    (res_nxt)
  );

endmodule
